FILE: sv/mavg_pkg.sv
// Shared types and constants for the boxcar moving average block.
`default_nettype none

package mavg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W = 24;
  localparam int CFG_W = 8;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [CFG_W-1:0] WINDOW_RESET = 8'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } mavg_state_t;

endpackage

`default_nettype wire

FILE: sv/moving_average_u16_top.sv
// Boxcar moving average of unsigned 16-bit samples with a bit-serial divider.
`default_nettype none

// Each accepted sample replaces the oldest one in a ring of window_length entries, updates a
// running sum and produces one average, the sum divided by the window length and truncated.
// An item passes through ST_READ, ST_DIV and ST_DONE from acceptance to a result on the
// output register. The ring is read at the accepting edge. ST_READ does the sum update and
// ring write, ST_DIV runs a restoring divider that retires one quotient bit per cycle, and
// ST_DONE loads the output register. The next sample is accepted once that result has been
// loaded, so no new sample is taken while one is in flight. A stalled result holds the block for as long as the stall.
// Writing window_length (0 acts as 1, values above RING_DEPTH act as RING_DEPTH) empties the
// window at once. Ring entries not yet written since then read as zero, so no clearing pass is
// needed after reset or a write.
module moving_average_u16_top
  import mavg_pkg::*;
#(
  parameter int RING_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_W-1:0]    window_length,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     average_valid,
  input  wire logic                average_stall,
  output logic [SAMPLE_W-1:0]      average
);

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int LEN_W = $clog2(RING_DEPTH + 1);
  localparam int LEN_RST = (int'(WINDOW_RESET) > RING_DEPTH) ? RING_DEPTH : int'(WINDOW_RESET);
  localparam logic [CFG_W:0] DEPTH_LIMIT = (CFG_W + 1)'(RING_DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  mavg_state_t state, state_next;

  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] sample_reg;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    sum_next;
  logic [ADDR_W-1:0]   pos;
  logic [LEN_W:0]      pos_inc;
  logic                pos_wrap;
  logic                filled;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    len_next;
  logic [SUM_W-1:0]    quo;
  logic [LEN_W-1:0]    rem;
  logic [LEN_W:0]      trial;
  logic [LEN_W:0]      diff;
  logic                quo_bit;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] old_sample;

  logic cfg_write;
  logic sample_take;
  logic out_free;
  logic div_last;

  always_comb begin
    logic [CFG_W:0] wl;
    wl = {1'b0, window_length};
    if (wl == '0) begin
      wl = (CFG_W + 1)'(1);
    end else if (wl > DEPTH_LIMIT) begin
      wl = DEPTH_LIMIT;
    end
    len_next = LEN_W'(wl);
  end

  assign out_free = !average_valid || !average_stall;
  assign cfg_write = cfg_valid && cfg_ready;
  assign sample_take = sample_valid && !sample_stall;
  assign div_last = (state == ST_DIV) && (step == LAST_STEP);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_take) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sample_stall = 1'b1;
    cfg_ready = 1'b0;
    unique case (state) inside
      ST_IDLE: begin
        sample_stall = cfg_valid;
        cfg_ready = 1'b1;
      end
      ST_READ, ST_DIV, ST_DONE: begin
        sample_stall = 1'b1;
        cfg_ready = 1'b0;
      end
      default: begin
        sample_stall = 1'b1;
        cfg_ready = 1'b0;
      end
    endcase
  end

  assign old_sample = filled ? rd_data : '0;
  assign sum_next = running_sum - SUM_W'(old_sample) + SUM_W'(sample_reg);
  assign pos_inc = (LEN_W + 1)'(pos) + (LEN_W + 1)'(1);
  assign pos_wrap = pos_inc >= {1'b0, len};

  assign trial = {rem, quo[SUM_W-1]};
  assign diff = trial - {1'b0, len};
  assign quo_bit = trial >= {1'b0, len};

  always_ff @(posedge clk) begin
    rd_data <= ring[pos];
    if (state == ST_READ) begin
      ring[pos] <= sample_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      sample_reg <= sample;
    end
    if (state == ST_READ) begin
      quo <= sum_next;
      rem <= '0;
      step <= '0;
    end else if (state == ST_DIV) begin
      quo <= {quo[SUM_W-2:0], quo_bit};
      rem <= quo_bit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      step <= step + STEP_W'(1);
    end
    if ((state == ST_DONE) && out_free) begin
      average <= quo[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      len <= LEN_W'(LEN_RST);
      running_sum <= '0;
      pos <= '0;
      filled <= 1'b0;
      average_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        len <= len_next;
        running_sum <= '0;
        pos <= '0;
        filled <= 1'b0;
      end else if (state == ST_READ) begin
        running_sum <= sum_next;
        if (pos_wrap) begin
          pos <= '0;
          filled <= 1'b1;
        end else begin
          pos <= pos_inc[ADDR_W-1:0];
        end
      end
      if ((state == ST_DONE) && out_free) begin
        average_valid <= 1'b1;
      end else if (!average_stall) begin
        average_valid <= 1'b0;
      end
    end
  end

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    (LEN_W + 1)'(pos) < {1'b0, len})
    else $error("write position is outside the window");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (running_sum == '0) && (pos == '0) && !filled)
    else $error("window not emptied after a length write");

  a_take_starts_read: assert property (@(posedge clk) disable iff (rst)
    sample_take |=> state == ST_READ)
    else $error("accepted sample did not start a ring read");

  a_result_from_divider: assert property (@(posedge clk) disable iff (rst)
    $rose(average_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared without a finished division");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the boxcar moving average block with a built-in window predictor.
module testbench
  import mavg_pkg::*;
();

  localparam int RING_DEPTH = 256;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    window_length = '0;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                average_valid;
  logic                average_stall = 1'b0;
  logic [SAMPLE_W-1:0] average;

  logic [SAMPLE_W-1:0] ring_model [RING_DEPTH];
  logic [SUM_W-1:0]    window_sum;
  logic [7:0]          ring_pos;
  logic [CFG_W-1:0]    window_cfg;

  logic [SAMPLE_W-1:0] expected_averages [$];
  int unsigned         failures = 0;
  bit                  idle_enable = 1'b1;
  int unsigned         stall_left = 0;

  moving_average_u16_top #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_length(window_length),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .average_valid(average_valid),
    .average_stall(average_stall),
    .average      (average)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void clear_window_model();
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_model[i] = '0;
    end
    window_sum = '0;
    ring_pos = '0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] next_average(input logic [SAMPLE_W-1:0] s);
    logic [8:0] len;
    logic [8:0] pos;
    len = (window_cfg == 0) ? 9'd1 : {1'b0, window_cfg};
    if (len > RING_DEPTH) begin
      len = 9'(RING_DEPTH);
    end
    pos = {1'b0, ring_pos};
    if (pos >= len) begin
      pos = '0;
    end
    window_sum = window_sum - ring_model[pos[7:0]] + s;
    ring_model[pos[7:0]] = s;
    pos = pos + 9'd1;
    if (pos >= len) begin
      pos = '0;
    end
    ring_pos = pos[7:0];
    return SAMPLE_W'(window_sum / len);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(input bit high_values);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: begin
        if (high_values) begin
          return SAMPLE_W'($urandom_range(60000, 65535));
        end
        return SAMPLE_W'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  // Result side: random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 3);
      average_stall <= 1'b1;
    end else begin
      average_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && average_valid && !average_stall) begin
      if (expected_averages.size() == 0) begin
        $error("average: unexpected result %0d", average);
        failures++;
      end else begin
        if (average !== expected_averages[0]) begin
          $error("average: expected %0d, actual %0d", expected_averages[0], average);
          failures++;
        end
        void'(expected_averages.pop_front());
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    expected_averages.push_back(next_average(s));
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] len);
    drain_results();
    @(posedge clk);
    cfg_valid <= 1'b1;
    window_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_cfg = len;
    clear_window_model();
  endtask

  task automatic test_reset_window();
    repeat (8) send_sample('1);
    send_sample('0);
    drain_results();
  endtask

  task automatic test_zero_window();
    write_window('0);
    send_sample('1);
    send_sample('0);
    send_sample(16'd1);
    send_sample(16'h8000);
    drain_results();
  endtask

  // A write of the same value must still empty the window.
  task automatic test_rewrite_clears();
    write_window(8'd2);
    send_sample('1);
    send_sample('1);
    write_window(8'd2);
    send_sample(16'd100);
    drain_results();
  endtask

  task automatic test_extreme_windows();
    write_window(8'd255);
    repeat (3) send_sample('1);
    write_window(8'd1);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    drain_results();
  endtask

  task automatic test_random_windows();
    logic [CFG_W-1:0] len;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: len = 8'd0;
        1: len = 8'd1;
        2: len = 8'd2;
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            len = CFG_W'($urandom_range(0, 255));
          end else begin
            len = CFG_W'($urandom_range(1, 16));
          end
        end
      endcase
      write_window(len);
      repeat (100) send_sample(random_sample($urandom_range(0, 3) == 0));
    end
    drain_results();
  endtask

  // Near-full-scale samples over the widest window drive the sum close to its limit.
  task automatic test_long_window();
    write_window(8'd255);
    for (int i = 0; i < 600; i++) begin
      if (i == 300) begin
        drain_results();
      end
      send_sample(random_sample($urandom_range(0, 4) != 0));
    end
    drain_results();
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    write_window(CFG_W'($urandom_range(1, 32)));
    repeat (350) send_sample(random_sample(1'b0));
    drain_results();
  endtask

  initial begin
    window_cfg = WINDOW_RESET;
    clear_window_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_window();
    test_zero_window();
    test_rewrite_clears();
    test_extreme_windows();
    test_random_windows();
    test_long_window();
    test_back_to_back();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mavg_pkg.sv
sv/moving_average_u16_top.sv
test/testbench.sv
